[sv/bsdp_pkg.sv]
package bsdp_pkg;

	// Header check outcome codes
	localparam logic [2:0] HDR_OK         = 3'd0;
	localparam logic [2:0] HDR_BAD_UUID   = 3'd1;
	localparam logic [2:0] HDR_NO_DATA    = 3'd2;
	localparam logic [2:0] HDR_DUPLICATE  = 3'd3;
	localparam logic [2:0] HDR_BAD_PROD   = 3'd4;
	localparam logic [2:0] HDR_TOO_SHORT  = 3'd5;

	localparam logic [15:0] SERVICE_UUID   = 16'hFE95;
	localparam logic [15:0] PRODUCT_ID_RST = 16'd1161;
	localparam logic [15:0] TYPE_BATTERY   = 16'h0A10;
	localparam logic [15:0] TYPE_SCORE     = 16'h1000;

	// Flags byte bits
	localparam int FLAG_ENCRYPTED = 3;
	localparam int FLAG_OFFSET12  = 5;
	localparam int FLAG_DATA      = 6;

	// Header byte positions
	localparam logic [7:0] POS_FLAGS    = 8'd0;
	localparam logic [7:0] POS_PROD_LO  = 8'd2;
	localparam logic [7:0] POS_PROD_HI  = 8'd3;
	localparam logic [7:0] POS_FRAME    = 8'd4;
	localparam logic [7:0] POS_MIN_LEN  = 8'd5;
	localparam logic [7:0] POS_REC_LONG = 8'd12;
	localparam logic [7:0] POS_REC_STD  = 8'd11;
	localparam logic [7:0] POS_MAX      = 8'd255;

	localparam logic [7:0] SCORE_LEAD   = 8'h01;
	localparam logic [2:0] LEN_MAX      = 3'd4;

	// Record parser phases
	localparam logic [2:0] PH_TYPE_HI = 3'd0;
	localparam logic [2:0] PH_TYPE_LO = 3'd1;
	localparam logic [2:0] PH_LENGTH  = 3'd2;
	localparam logic [2:0] PH_DATA0   = 3'd3;

	typedef struct packed {
		logic       found;
		logic       battery_valid;
		logic [7:0] battery_percent;
		logic       score_valid;
		logic [7:0] score_value;
	} bsdp_vals_t;

	typedef struct packed {
		logic       en;
		logic       clear;
		logic [7:0] data;
	} bsdp_rec_ctl_t;

endpackage

[sv/bsdp_if.sv]
interface bsdp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] uuid_value;
	logic [7:0]  data_byte;
	logic        last_byte;

	modport source (output valid, output uuid_value, output data_byte, output last_byte,
		input ready);
	modport sink (input valid, input uuid_value, input data_byte, input last_byte,
		output ready);
endinterface

interface bsdp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] header_status;
	logic       encrypted;
	logic       values_found;
	logic       battery_valid;
	logic [7:0] battery_percent;
	logic       score_valid;
	logic [7:0] score_value;

	modport source (output valid, output header_status, output encrypted,
		output values_found, output battery_valid, output battery_percent,
		output score_valid, output score_value, input ready);
	modport sink (input valid, input header_status, input encrypted,
		input values_found, input battery_valid, input battery_percent,
		input score_valid, input score_value, output ready);
endinterface

[sv/bsdp_record_parser.sv]
module bsdp_record_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bsdp_pkg::bsdp_rec_ctl_t ctl,
	output bsdp_pkg::bsdp_vals_t   vals_next
);
	import bsdp_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] type_q, type_d;
	logic [2:0]  len_q, len_d;
	logic [7:0]  first_q, first_d;
	logic        stopped_q, stopped_d;
	bsdp_vals_t  vals_q, vals_d;
	logic [2:0]  idx;
	logic [7:0]  first_eff;

	assign idx       = phase_q - PH_DATA0;
	assign first_eff = (idx == 3'd0) ? ctl.data : first_q;

	// Advance the type/length/value walk by one byte
	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		len_d     = len_q;
		first_d   = first_q;
		stopped_d = stopped_q;
		vals_d    = vals_q;
		if (ctl.en && !stopped_q) begin
			case (phase_q)
				PH_TYPE_HI: begin
					type_d  = {ctl.data, 8'h00};
					phase_d = PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					type_d[7:0] = ctl.data;
					phase_d     = PH_LENGTH;
				end
				PH_LENGTH: begin
					if (ctl.data == 8'd0 || ctl.data > {5'd0, LEN_MAX}) begin
						stopped_d = 1'b1;
						phase_d   = PH_TYPE_HI;
					end else begin
						len_d   = ctl.data[2:0];
						phase_d = PH_DATA0;
					end
				end
				default: begin
					first_d = first_eff;
					if ({1'b0, idx} + 4'd1 >= {1'b0, len_q}) begin
						phase_d = PH_TYPE_HI;
						if (type_q == TYPE_BATTERY && len_q == 3'd1) begin
							vals_d.found           = 1'b1;
							vals_d.battery_valid   = 1'b1;
							vals_d.battery_percent = ctl.data;
						end else if (type_q == TYPE_SCORE && len_q == 3'd2 &&
							first_eff == SCORE_LEAD) begin
							vals_d.found       = 1'b1;
							vals_d.score_valid = 1'b1;
							vals_d.score_value = ctl.data;
						end
					end else begin
						phase_d = phase_q + 3'd1;
					end
				end
			endcase
		end
	end

	assign vals_next = vals_d;

	// Hold the walk state; drop it at packet end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE_HI;
			type_q    <= '0;
			len_q     <= '0;
			first_q   <= '0;
			stopped_q <= 1'b0;
			vals_q    <= '0;
		end else if (ctl.clear) begin
			phase_q   <= PH_TYPE_HI;
			type_q    <= '0;
			len_q     <= '0;
			first_q   <= '0;
			stopped_q <= 1'b0;
			vals_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			len_q     <= len_d;
			first_q   <= first_d;
			stopped_q <= stopped_d;
			vals_q    <= vals_d;
		end
	end

endmodule

[sv/beacon_service_data_parser_unit.sv]
// Channel     Dir  Handshake     Carries
// item_in     in   valid/ready   uuid_value, data_byte, last_byte
// report_out  out  valid/ready   header_status .. score_value
// product_id  in   we/wdata      accepted product id (16 bits)
//
// One item per cycle while item_in.ready is high; a packet's report enters the
// output register when its last byte is taken. item_in.ready is low only while
// a report waits in the output register and report_out.ready is low. Reset
// clears the packet state and the frame counter, and loads product id 1161.
module beacon_service_data_parser_unit (
	input  logic clk,
	input  logic arst_n,
	bsdp_in_if.sink    item_in,
	bsdp_out_if.source report_out,
	input  logic        product_id_we,
	input  logic [15:0] product_id_wdata
);
	import bsdp_pkg::*;

	logic [15:0]   product_id_q;
	logic [7:0]    pos_q, pos_next;
	logic [7:0]    flags_q, flags_d;
	logic [7:0]    prod_lo_q;
	logic [7:0]    frame_q, frame_d;
	logic [2:0]    hdr_q, hdr_d, status;
	logic [7:0]    offset;
	logic          acc;
	logic          out_valid_q;
	bsdp_rec_ctl_t rec_ctl;
	bsdp_vals_t    vals_next;

	assign acc           = item_in.valid && item_in.ready;
	assign item_in.ready = !out_valid_q || report_out.ready;

	// Header checks by byte position
	always_comb begin
		flags_d = flags_q;
		hdr_d   = hdr_q;
		frame_d = frame_q;
		case (pos_q)
			POS_FLAGS: begin
				flags_d = item_in.data_byte;
				if (item_in.uuid_value != SERVICE_UUID)
					hdr_d = HDR_BAD_UUID;
				else if (!item_in.data_byte[FLAG_DATA])
					hdr_d = HDR_NO_DATA;
				else
					hdr_d = HDR_OK;
			end
			POS_PROD_HI: begin
				if (hdr_q == HDR_OK && {item_in.data_byte, prod_lo_q} != product_id_q)
					hdr_d = HDR_BAD_PROD;
			end
			POS_FRAME: begin
				if (hdr_q == HDR_OK || hdr_q == HDR_BAD_PROD) begin
					if (item_in.data_byte == frame_q)
						hdr_d = HDR_DUPLICATE;
					else
						frame_d = item_in.data_byte;
				end
			end
			default: ;
		endcase
	end

	// Feed record bytes once the header is good and in the clear
	assign offset      = flags_q[FLAG_OFFSET12] ? POS_REC_LONG : POS_REC_STD;
	assign rec_ctl.en  = acc && pos_q >= POS_MIN_LEN && hdr_d == HDR_OK &&
		!flags_d[FLAG_ENCRYPTED] && pos_q >= offset;
	assign rec_ctl.clear = acc && item_in.last_byte;
	assign rec_ctl.data  = item_in.data_byte;

	bsdp_record_parser u_rec (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rec_ctl),
		.vals_next (vals_next)
	);

	assign pos_next = (pos_q == POS_MAX) ? pos_q : pos_q + 8'd1;
	assign status   = ((hdr_d == HDR_OK || hdr_d == HDR_BAD_PROD) && pos_next < POS_MIN_LEN)
		? HDR_TOO_SHORT : hdr_d;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			product_id_q <= PRODUCT_ID_RST;
		else if (product_id_we)
			product_id_q <= product_id_wdata;
	end

	// Advance packet state; clear it on the last byte, when the report is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			flags_q   <= '0;
			prod_lo_q <= '0;
			frame_q   <= '0;
			hdr_q     <= HDR_OK;
		end else if (acc) begin
			frame_q <= frame_d;
			if (item_in.last_byte) begin
				pos_q     <= '0;
				flags_q   <= '0;
				prod_lo_q <= '0;
				hdr_q     <= HDR_OK;
			end else begin
				pos_q   <= pos_next;
				flags_q <= flags_d;
				hdr_q   <= hdr_d;
				if (pos_q == POS_PROD_LO)
					prod_lo_q <= item_in.data_byte;
			end
		end
	end

	// Output register: load on last byte, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (acc && item_in.last_byte)
			out_valid_q <= 1'b1;
		else if (report_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc && item_in.last_byte) begin
			report_out.header_status <= status;
			if (status == HDR_OK) begin
				report_out.encrypted       <= flags_d[FLAG_ENCRYPTED];
				report_out.values_found    <= vals_next.found;
				report_out.battery_valid   <= vals_next.battery_valid;
				report_out.battery_percent <= vals_next.battery_percent;
				report_out.score_valid     <= vals_next.score_valid;
				report_out.score_value     <= vals_next.score_value;
			end else begin
				report_out.encrypted       <= 1'b0;
				report_out.values_found    <= 1'b0;
				report_out.battery_valid   <= 1'b0;
				report_out.battery_percent <= '0;
				report_out.score_valid     <= 1'b0;
				report_out.score_value     <= '0;
			end
		end
	end

	assign report_out.valid = out_valid_q;

endmodule

[bench/beacon_service_data_parser_unit_tb.sv]
module beacon_service_data_parser_unit_tb;
	import bsdp_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_PKT_BYTES = 262;

	typedef struct packed {
		logic [15:0] uuid;
		logic [7:0]  data;
		logic        last;
	} byte_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       encrypted;
		bsdp_vals_t vals;
	} report_t;

	typedef enum int {
		REC_BATTERY,
		REC_SCORE,
		REC_SCORE_BADLEAD,
		REC_BATT_BADLEN,
		REC_SCORE_BADLEN,
		REC_OTHER,
		REC_BADLEN
	} rec_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Driven inputs, all known from time zero
	logic        drv_valid = 1'b0;
	logic [15:0] drv_uuid = 16'h0000;
	logic [7:0]  drv_data = 8'h00;
	logic        drv_last = 1'b0;
	logic        drv_ready = 1'b0;
	logic        product_id_we = 1'b0;
	logic [15:0] product_id_wdata = 16'h0000;

	bsdp_in_if  item_ch ();
	bsdp_out_if report_ch ();

	assign item_ch.valid      = drv_valid;
	assign item_ch.uuid_value = drv_uuid;
	assign item_ch.data_byte  = drv_data;
	assign item_ch.last_byte  = drv_last;
	assign report_ch.ready    = drv_ready;

	beacon_service_data_parser_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_in          (item_ch),
		.report_out       (report_ch),
		.product_id_we    (product_id_we),
		.product_id_wdata (product_id_wdata)
	);

	// Bench bookkeeping
	byte_item_t byte_feed[$];
	report_t    awaited_reports[$];
	logic [7:0] pkt_buf[$];
	logic       byte_taken = 1'b0;
	logic       calm = 1'b0;
	int         feed_gap = 0;
	int         stall_left = 0;
	int         queued_cnt = 0;
	int         accepted_cnt = 0;
	int         packets_cnt = 0;
	int         reports_cnt = 0;
	int         settings_cnt = 0;
	int         error_cnt = 0;
	int         quiet_cycles = 0;
	logic [7:0] gen_fc = 8'h00;

	// Parser model state
	logic [15:0] m_pid = PRODUCT_ID_RST;
	logic [7:0]  m_pos = 8'h00;
	logic [7:0]  m_flags = 8'h00;
	logic [7:0]  m_prod_lo = 8'h00;
	logic [7:0]  m_last_fc = 8'h00;
	logic [2:0]  m_hdr = HDR_OK;
	logic [2:0]  m_phase = PH_TYPE_HI;
	logic [15:0] m_type = 16'h0000;
	logic [2:0]  m_len = 3'd0;
	logic [7:0]  m_first = 8'h00;
	logic        m_stopped = 1'b0;
	bsdp_vals_t  m_vals = '0;

	always #5 clk = ~clk;

	// Mostly short gaps, a few long ones, none at all while calm
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Advance the parser model by one byte; give the report on the last byte
	task automatic parse_byte(input logic [15:0] uuid, input logic [7:0] b, input logic last,
		output logic has_rep, output report_t rep);
		logic [7:0] p;
		logic [7:0] offset;
		logic [2:0] idx;
		logic [2:0] hs;
		p = m_pos;
		has_rep = 1'b0;
		rep = '0;

		// header checks by position
		if (p == POS_FLAGS) begin
			m_flags = b;
			if (uuid != SERVICE_UUID)
				m_hdr = HDR_BAD_UUID;
			else if (!b[FLAG_DATA])
				m_hdr = HDR_NO_DATA;
			else
				m_hdr = HDR_OK;
		end else if (p == POS_PROD_LO) begin
			m_prod_lo = b;
		end else if (p == POS_PROD_HI) begin
			if (m_hdr == HDR_OK && {b, m_prod_lo} != m_pid)
				m_hdr = HDR_BAD_PROD;
		end else if (p == POS_FRAME) begin
			if (m_hdr == HDR_OK || m_hdr == HDR_BAD_PROD) begin
				if (b == m_last_fc)
					m_hdr = HDR_DUPLICATE;
				else
					m_last_fc = b;
			end
		end

		// type/length/value records once past the header
		offset = m_flags[FLAG_OFFSET12] ? POS_REC_LONG : POS_REC_STD;
		if (p >= POS_MIN_LEN && p >= offset && m_hdr == HDR_OK &&
			!m_flags[FLAG_ENCRYPTED] && !m_stopped) begin
			case (m_phase)
				PH_TYPE_HI: begin
					m_type = {b, 8'h00};
					m_phase = PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					m_type[7:0] = b;
					m_phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					if (b == 8'd0 || b > LEN_MAX) begin
						m_stopped = 1'b1;
						m_phase = PH_TYPE_HI;
					end else begin
						m_len = b[2:0];
						m_phase = PH_DATA0;
					end
				end
				default: begin
					idx = m_phase - PH_DATA0;
					if (idx == 3'd0)
						m_first = b;
					if (idx + 1 >= m_len) begin
						if (m_type == TYPE_BATTERY && m_len == 3'd1) begin
							m_vals.found = 1'b1;
							m_vals.battery_valid = 1'b1;
							m_vals.battery_percent = b;
						end else if (m_type == TYPE_SCORE && m_len == 3'd2 &&
							m_first == SCORE_LEAD) begin
							m_vals.found = 1'b1;
							m_vals.score_valid = 1'b1;
							m_vals.score_value = b;
						end
						m_phase = PH_TYPE_HI;
					end else begin
						m_phase = m_phase + 3'd1;
					end
				end
			endcase
		end

		if (m_pos != POS_MAX)
			m_pos = m_pos + 8'd1;

		// report and drop the per-packet state
		if (last) begin
			hs = m_hdr;
			if ((hs == HDR_OK || hs == HDR_BAD_PROD) && m_pos < POS_MIN_LEN)
				hs = HDR_TOO_SHORT;
			rep.status = hs;
			if (hs == HDR_OK) begin
				rep.encrypted = m_flags[FLAG_ENCRYPTED];
				rep.vals = m_vals;
			end
			has_rep = 1'b1;
			m_pos = 8'h00;
			m_flags = 8'h00;
			m_prod_lo = 8'h00;
			m_hdr = HDR_OK;
			m_phase = PH_TYPE_HI;
			m_type = 16'h0000;
			m_len = 3'd0;
			m_first = 8'h00;
			m_stopped = 1'b0;
			m_vals = '0;
		end
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			error_cnt = error_cnt + 1;
			if (error_cnt <= 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endtask

	// Move the packet buffer into the feed, marking the final byte
	task automatic flush_packet(input logic [15:0] uuid);
		byte_item_t it;
		for (int i = 0; i < pkt_buf.size(); i++) begin
			it.uuid = (i == 0) ? uuid : 16'($urandom_range(0, 65535));
			it.data = pkt_buf[i];
			it.last = (i == pkt_buf.size() - 1);
			byte_feed.push_back(it);
			queued_cnt = queued_cnt + 1;
		end
		pkt_buf.delete();
		packets_cnt = packets_cnt + 1;
	endtask

	task automatic add_bytes(input int n);
		repeat (n) pkt_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_record(input rec_kind_e kind);
		int n;
		case (kind)
			REC_BATTERY: begin
				pkt_buf.push_back(TYPE_BATTERY[15:8]);
				pkt_buf.push_back(TYPE_BATTERY[7:0]);
				pkt_buf.push_back(8'd1);
				add_bytes(1);
			end
			REC_SCORE, REC_SCORE_BADLEAD: begin
				pkt_buf.push_back(TYPE_SCORE[15:8]);
				pkt_buf.push_back(TYPE_SCORE[7:0]);
				pkt_buf.push_back(8'd2);
				if (kind == REC_SCORE)
					pkt_buf.push_back(SCORE_LEAD);
				else
					add_bytes(1);
				add_bytes(1);
			end
			REC_BATT_BADLEN: begin
				n = $urandom_range(2, 4);
				pkt_buf.push_back(TYPE_BATTERY[15:8]);
				pkt_buf.push_back(TYPE_BATTERY[7:0]);
				pkt_buf.push_back(8'(n));
				add_bytes(n);
			end
			REC_SCORE_BADLEN: begin
				n = $urandom_range(0, 1) ? 1 : $urandom_range(3, 4);
				pkt_buf.push_back(TYPE_SCORE[15:8]);
				pkt_buf.push_back(TYPE_SCORE[7:0]);
				pkt_buf.push_back(8'(n));
				pkt_buf.push_back(SCORE_LEAD);
				add_bytes(n - 1);
			end
			REC_OTHER: begin
				n = $urandom_range(1, 4);
				add_bytes(2);
				pkt_buf.push_back(8'(n));
				add_bytes(n);
			end
			default: begin
				add_bytes(2);
				pkt_buf.push_back($urandom_range(0, 2) == 0 ? 8'd0 :
					8'($urandom_range(5, 255)));
				add_bytes($urandom_range(0, 6));
			end
		endcase
	endtask

	function automatic rec_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return REC_BATTERY;
		if (r < 50) return REC_SCORE;
		if (r < 58) return REC_SCORE_BADLEAD;
		if (r < 66) return REC_BATT_BADLEN;
		if (r < 74) return REC_SCORE_BADLEN;
		if (r < 92) return REC_OTHER;
		return REC_BADLEN;
	endfunction

	// Well-formed packet with random content; now and then cut short
	task automatic build_good(input logic [15:0] pid, input logic long_pkt);
		logic [7:0]  flags;
		logic [7:0]  offset;
		logic [15:0] prod;
		flags = 8'($urandom_range(0, 255)) | 8'h40;
		if ($urandom_range(0, 99) < 85)
			flags[FLAG_ENCRYPTED] = 1'b0;
		offset = flags[FLAG_OFFSET12] ? POS_REC_LONG : POS_REC_STD;
		if ($urandom_range(0, 99) >= 8)
			gen_fc = gen_fc + 8'($urandom_range(1, 255));
		prod = ($urandom_range(0, 99) < 85) ? pid : 16'($urandom_range(0, 65535));
		pkt_buf.push_back(flags);
		add_bytes(1);
		pkt_buf.push_back(prod[7:0]);
		pkt_buf.push_back(prod[15:8]);
		pkt_buf.push_back(gen_fc);
		while (pkt_buf.size() < offset)
			add_bytes(1);
		if (long_pkt) begin
			while (pkt_buf.size() < LONG_PKT_BYTES)
				add_record(($urandom_range(0, 3) == 0) ? REC_SCORE : REC_OTHER);
			add_record(REC_BATTERY);
		end else begin
			repeat ($urandom_range(0, 4)) add_record(pick_kind());
			if ($urandom_range(0, 99) < 20) begin
				repeat ($urandom_range(1, 3)) begin
					if (pkt_buf.size() > offset)
						void'(pkt_buf.pop_back());
				end
			end
		end
		flush_packet(SERVICE_UUID);
	endtask

	// Junk: random bytes, or a header that passes the first checks but ends early
	task automatic build_noise();
		if ($urandom_range(0, 1)) begin
			pkt_buf.push_back(8'($urandom_range(0, 255)) | ($urandom_range(0, 3) != 0 ?
				8'h40 : 8'h00));
			add_bytes($urandom_range(0, 3));
			flush_packet(SERVICE_UUID);
		end else begin
			add_bytes($urandom_range(1, 20));
			flush_packet($urandom_range(0, 3) == 0 ? SERVICE_UUID :
				16'($urandom_range(0, 65535)));
		end
	endtask

	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || awaited_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_product_id(input logic [15:0] v);
		product_id_we <= 1'b1;
		product_id_wdata <= v;
		@(negedge clk);
		product_id_we <= 1'b0;
		settings_cnt = settings_cnt + 1;
	endtask

	// Byte driver: hold an item until taken, then idle for a drawn gap
	always @(negedge clk) begin
		byte_item_t nxt;
		if ($urandom_range(0, 199) == 0)
			calm <= ~calm;
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (drv_valid && !byte_taken) begin
			// hold the current item
		end else if (feed_gap > 0) begin
			drv_valid <= 1'b0;
			feed_gap <= feed_gap - 1;
		end else if (byte_feed.size() != 0) begin
			nxt = byte_feed.pop_front();
			drv_valid <= 1'b1;
			drv_uuid <= nxt.uuid;
			drv_data <= nxt.data;
			drv_last <= nxt.last;
			feed_gap <= draw_gap();
		end else begin
			drv_valid <= 1'b0;
		end
	end

	// Report sink: stall at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			drv_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			drv_ready <= 1'b1;
			stall_left <= draw_gap();
		end
	end

	// Monitor: check reports against the oldest prediction, then predict
	always @(posedge clk) begin
		report_t want;
		report_t pred;
		logic    has_rep;
		if (arst_n) begin
			if (product_id_we)
				m_pid = product_id_wdata;
			if (report_ch.valid && report_ch.ready) begin
				reports_cnt = reports_cnt + 1;
				if (awaited_reports.size() == 0) begin
					error_cnt = error_cnt + 1;
					if (error_cnt <= 40)
						$display("%0t: report with none expected, status %0d", $time,
							report_ch.header_status);
				end else begin
					want = awaited_reports.pop_front();
					check_field("header_status", want.status, report_ch.header_status);
					check_field("encrypted", want.encrypted, report_ch.encrypted);
					check_field("values_found", want.vals.found, report_ch.values_found);
					check_field("battery_valid", want.vals.battery_valid,
						report_ch.battery_valid);
					check_field("battery_percent", want.vals.battery_percent,
						report_ch.battery_percent);
					check_field("score_valid", want.vals.score_valid, report_ch.score_valid);
					check_field("score_value", want.vals.score_value, report_ch.score_value);
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				parse_byte(item_ch.uuid_value, item_ch.data_byte, item_ch.last_byte,
					has_rep, pred);
				if (has_rep)
					awaited_reports.push_back(pred);
				accepted_cnt = accepted_cnt + 1;
			end
		end
		byte_taken <= arst_n && item_ch.valid && item_ch.ready;
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (report_ch.valid && report_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [15:0] phase_pid [4];
		int          target;
		phase_pid[0] = 16'h0000;
		phase_pid[1] = 16'hFFFF;
		phase_pid[2] = 16'($urandom_range(1, 65534));
		phase_pid[3] = PRODUCT_ID_RST;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: wrong uuid, no data flag, wrong uuid with all flags set
		pkt_buf.push_back(8'h40);
		flush_packet(16'h0000);
		pkt_buf.push_back(8'hBF);
		flush_packet(SERVICE_UUID);
		pkt_buf.push_back(8'hFF);
		flush_packet(16'hFFFF);
		// unknown product still takes the frame counter, then a duplicate
		pkt_buf = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hFF};
		flush_packet(SERVICE_UUID);
		pkt_buf = '{8'h40, 8'hFF, PRODUCT_ID_RST[7:0], PRODUCT_ID_RST[15:8], 8'hFF};
		flush_packet(SERVICE_UUID);
		// good packet with a battery record at full scale
		pkt_buf = '{8'h40, 8'h00, PRODUCT_ID_RST[7:0], PRODUCT_ID_RST[15:8], 8'h00};
		add_bytes(6);
		add_record(REC_BATTERY);
		pkt_buf[pkt_buf.size() - 1] = 8'hFF;
		flush_packet(SERVICE_UUID);
		gen_fc = 8'h00;

		// random phases, each under its own product id
		target = queued_cnt;
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_product_id(phase_pid[ph]);
			target = target + 380;
			if (ph == 2)
				build_good(phase_pid[ph], 1'b1);
			while (queued_cnt < target) begin
				if ($urandom_range(0, 99) < 75)
					build_good(phase_pid[ph], 1'b0);
				else
					build_noise();
			end
		end
		wait_idle();

		$display("Covered %0d packets (%0d bytes), %0d reports checked, %0d product id settings",
			packets_cnt, accepted_cnt, reports_cnt, settings_cnt);
		$display("including extremes 0x0000 and 0xFFFF and one packet past 255 bytes");
		if (error_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", error_cnt);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
sv/bsdp_pkg.sv
sv/bsdp_if.sv
sv/bsdp_record_parser.sv
sv/beacon_service_data_parser_unit.sv
bench/beacon_service_data_parser_unit_tb.sv
